[rtl/d2mf_pkg.sv]
// Package for the double to minifloat converter: widths, register indexes,
// classification codes and the queue entry type. No dependencies.
`timescale 1ns / 1ps
package d2mf_pkg;

  localparam int unsigned ValueWidth  = 64;
  localparam int unsigned EwWidth     = 4;
  localparam int unsigned FwWidth     = 6;
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned CfgDatWidth = 6;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [CfgIdxWidth-1:0] RegExpWidth  = 1'b0;
  localparam logic [CfgIdxWidth-1:0] RegFracWidth = 1'b1;

  typedef enum logic [1:0] {
    ClsZero   = 2'd0,
    ClsInf    = 2'd1,
    ClsNan    = 2'd2,
    ClsFinite = 2'd3
  } cls_e;

  // Classified item handed from front to back.
  typedef struct packed {
    logic        sign;
    cls_e        cls;
    logic [52:0] mant;   // normalized, hidden bit at 52
    logic [12:0] texp;   // signed biased target exponent before rounding
    logic [3:0]  ew;
    logic [5:0]  fw;
  } item_t;

endpackage

[rtl/double_to_minifloat_converter_unit.sv]
// Top level of the double to minifloat converter: config registers, front,
// queue and back parts. Depends on d2mf_pkg, d2mf_front, d2mf_queue, d2mf_back.
//
// Channel   | Ports                       | Handshake
// input     | value_bits_i                | push_i, full_o
// result    | result_bits_o, overflowed_o | empty_o, pop_i
// config    | cfg_we_i, cfg_idx_i, cfg_data_i | write when cfg_we_i
//
// One item per cycle sustained while pop_i takes each result; a result shows on the result
// ports once it has passed the front register, the queue and the result register.
// Reset clears control state and loads exponent width 8, fraction width 23.
// A stalled result stalls the back part; the two-entry queue absorbs the front.
`timescale 1ns / 1ps
module double_to_minifloat_converter_unit
  import d2mf_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  output logic                   full_o,
  input  logic [ValueWidth-1:0]  value_bits_i,
  output logic                   empty_o,
  input  logic                   pop_i,
  output logic [ValueWidth-1:0]  result_bits_o,
  output logic                   overflowed_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgDatWidth-1:0] cfg_data_i
);

  logic [EwWidth-1:0] ew_q;
  logic [FwWidth-1:0] fw_q;
  logic  f_valid, q_full, q_empty, b_ready;
  item_t f_item, q_item;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ew_q <= 4'd8;
      fw_q <= 6'd23;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegExpWidth:  ew_q <= cfg_data_i[EwWidth-1:0];
        RegFracWidth: fw_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  d2mf_front u_front (
    .clk_i, .rst_ni,
    .valid_i(push_i && !full_o), .value_bits_i,
    .ew_i(ew_q), .fw_i(fw_q),
    .valid_o(f_valid), .item_o(f_item), .ready_i(!q_full)
  );

  d2mf_queue #(.Depth(Depth)) u_queue (
    .clk_i, .rst_ni,
    .push_i(f_valid), .data_i(f_item), .full_o(q_full),
    .pop_i(b_ready), .data_o(q_item), .empty_o(q_empty)
  );

  d2mf_back u_back (
    .clk_i, .rst_ni,
    .valid_i(!q_empty), .item_i(q_item), .ready_o(b_ready),
    .empty_o, .pop_i, .result_bits_o, .overflowed_o
  );

  // Front holds when full
  assign full_o = f_valid && q_full;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> f_valid)
    else $error("full without pending item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |=> f_valid && $stable(f_item))
    else $error("front item changed while blocked");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_empty)
    else $error("queue full and empty at once");

endmodule

[rtl/d2mf_front.sv]
// Front stage: clamps configuration, classifies the double, normalizes
// subnormals and computes the target exponent. Depends on d2mf_pkg.
`timescale 1ns / 1ps
module d2mf_front
  import d2mf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [ValueWidth-1:0] value_bits_i,
  input  logic [EwWidth-1:0]    ew_i,
  input  logic [FwWidth-1:0]    fw_i,
  output logic                  valid_o,
  output item_t                 item_o,
  input  logic                  ready_i
);

  logic        adv;
  logic        valid_q;
  item_t       item_q, item_d;
  logic [10:0] dexp;
  logic [51:0] dfrac;
  logic [5:0]  lz;
  logic [3:0]  ew;
  logic [5:0]  fw;
  logic [12:0] e_unb;
  logic [12:0] bias;

  assign dexp  = value_bits_i[62:52];
  assign dfrac = value_bits_i[51:0];

  // Count leading zeros of the subnormal fraction
  always_comb begin
    lz = 6'd52;
    for (int i = 0; i < 52; i++) begin
      if (dfrac[i]) lz = 6'(51 - i);
    end
  end

  // Clamp registers and classify
  always_comb begin
    ew = (ew_i < 4'd2) ? 4'd2 : ((ew_i > 4'd11) ? 4'd11 : ew_i);
    fw = (fw_i < 6'd1) ? 6'd1 : ((fw_i > 6'd52) ? 6'd52 : fw_i);
    bias = 13'((14'd1 << (ew - 4'd1)) - 14'd1);
    item_d.sign = value_bits_i[63];
    item_d.ew = ew;
    item_d.fw = fw;
    if (dexp == 11'h7FF) begin
      item_d.cls = (dfrac != '0) ? ClsNan : ClsInf;
    end else if (dexp == '0 && dfrac == '0) begin
      item_d.cls = ClsZero;
    end else begin
      item_d.cls = ClsFinite;
    end
    if (dexp == '0) begin
      item_d.mant = {1'b0, dfrac} << (lz + 6'd1);
      e_unb = 13'(-13'sd1023) - 13'(lz);
    end else begin
      item_d.mant = {1'b1, dfrac};
      e_unb = 13'(dexp) - 13'd1023;
    end
    item_d.texp = e_unb + bias;
  end

  assign adv = !valid_q || ready_i;

  // Advance the stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/d2mf_queue.sv]
// Small FIFO between front and back parts, built from registers.
// Depends on d2mf_pkg.
`timescale 1ns / 1ps
module d2mf_queue
  import d2mf_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  item_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  // Count never passes depth, pop never from empty, and a lone push or pop steps the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= (PtrW+1)'(Depth))
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count lost a push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop && !do_push |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("queue count lost a pop");

endmodule

[rtl/d2mf_back.sv]
// Back stage: rounds to nearest even, handles overflow and subnormals,
// packs the result into an output register. Depends on d2mf_pkg.
`timescale 1ns / 1ps
module d2mf_back
  import d2mf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  item_t                 item_i,
  output logic                  ready_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output logic [ValueWidth-1:0] result_bits_o,
  output logic                  overflowed_o
);

  logic                  valid_q;
  logic [ValueWidth-1:0] res_q, res_d;
  logic                  ovf_q, ovf_d;
  logic                  adv;

  logic [63:0] sign_pos, exp_ones, frac_mask, mant64, rem, half, q, qn;
  logic [12:0] emax, te;
  logic [12:0] sh;
  logic [6:0]  s;
  logic        flush;

  // Round and pack
  always_comb begin
    sign_pos  = 64'(item_i.sign) << (item_i.ew + item_i.fw);
    exp_ones  = ((64'd1 << item_i.ew) - 64'd1) << item_i.fw;
    frac_mask = (64'd1 << item_i.fw) - 64'd1;
    emax      = 13'((14'd1 << item_i.ew) - 14'd2);
    mant64    = 64'(item_i.mant);
    te        = item_i.texp;
    ovf_d     = 1'b0;
    if ($signed(te) >= 13'sd1) begin
      sh = 13'd52 - 13'(item_i.fw);
    end else begin
      sh = 13'd53 - 13'(item_i.fw) - te;
    end
    flush  = (sh >= 13'd54);
    s      = flush ? 7'd0 : sh[6:0];
    q      = mant64 >> s;
    rem    = mant64 & ((64'd1 << s) - 64'd1);
    half   = (s == 7'd0) ? 64'd0 : (64'd1 << (s - 7'd1));
    if (s != 7'd0 && (rem > half || (rem == half && q[0]))) q = q + 64'd1;
    if (flush) q = '0;
    qn = q;
    case (item_i.cls)
      ClsNan:  res_d = sign_pos | exp_ones | (64'd1 << (item_i.fw - 6'd1));
      ClsInf:  res_d = sign_pos | exp_ones;
      ClsZero: res_d = sign_pos;
      ClsFinite: begin
        if ($signed(te) >= 13'sd1) begin
          if ((q >> (item_i.fw + 6'd1)) != '0) begin
            qn = q >> 1;
            te = te + 13'd1;
          end
          if ($signed(te) > $signed(emax)) begin
            res_d = sign_pos | exp_ones;
            ovf_d = 1'b1;
          end else begin
            res_d = sign_pos | (64'(te[11:0]) << item_i.fw) | (qn & frac_mask);
          end
        end else begin
          res_d = sign_pos | q;
        end
      end
      default: res_d = sign_pos;
    endcase
  end

  assign adv     = !valid_q || pop_i;
  assign ready_o = adv;

  // Hold the result until popped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      res_q <= res_d;
      ovf_q <= ovf_d;
    end
  end

  assign empty_o       = !valid_q;
  assign result_bits_o = res_q;
  assign overflowed_o  = ovf_q;

  // Result held while waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !pop_i |=> valid_q && $stable(res_q))
    else $error("result changed while waiting");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !pop_i |=> $stable(ovf_q))
    else $error("overflow flag changed while waiting");
  // Overflow carries an infinity encoding, so an overflowed result is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && ovf_q |-> res_q != '0)
    else $error("overflow with zero result");

endmodule

[verif/testbench.sv]
// Self-checking testbench for double_to_minifloat_converter_unit: directed table,
// then random doubles over several target formats. Depends on d2mf_pkg and the RTL.
`timescale 1ns / 1ps
module testbench;
  import d2mf_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned RandPerFmt = 92;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   push_i = 1'b0;
  logic                   full_o;
  logic [ValueWidth-1:0]  value_bits_i = '0;
  logic                   empty_o;
  logic                   pop_i = 1'b0;
  logic [ValueWidth-1:0]  result_bits_o;
  logic                   overflowed_o;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [CfgDatWidth-1:0] cfg_data_i = '0;

  double_to_minifloat_converter_unit dut (.*);

  typedef struct {
    logic [63:0] bits;
    logic        ovf;
  } mini_t;

  typedef struct {
    logic [63:0] value;
    logic        typed;
    logic [63:0] bits;
    logic        ovf;
  } vec_t;

  // Shadow of the format registers
  logic [3:0] exp_w_q = 4'd8;
  logic [5:0] frac_w_q = 6'd23;

  mini_t       pending_q[$];
  int unsigned n_fail = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_ovf = 0;
  int unsigned n_formats = 0;
  int unsigned idle_cycles = 0;
  logic        send_burst = 1'b0;
  logic        recv_burst = 1'b0;

  // Clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_exp_w();
    if (exp_w_q < 2) return 2;
    if (exp_w_q > 11) return 11;
    return exp_w_q;
  endfunction

  function automatic int unsigned eff_frac_w();
    if (frac_w_q < 1) return 1;
    if (frac_w_q > 52) return 52;
    return frac_w_q;
  endfunction

  function automatic logic [63:0] shift_rne(input logic [63:0] m, input int unsigned s);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    q = m >> s;
    rem = m & ((64'd1 << s) - 64'd1);
    half = 64'd1 << (s - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q;
  endfunction

  // Convert one double to the current target format
  function automatic mini_t convert_double(input logic [63:0] v);
    mini_t       r;
    int unsigned ew;
    int unsigned fw;
    logic [10:0] dexp;
    logic [51:0] dfrac;
    logic [63:0] sign_pos;
    logic [63:0] exp_ones;
    logic [63:0] m;
    logic [63:0] q;
    int          bias;
    int          emax;
    int          e;
    int          te;
    int          s;
    ew = eff_exp_w();
    fw = eff_frac_w();
    dexp = v[62:52];
    dfrac = v[51:0];
    sign_pos = 64'(v[63]) << (ew + fw);
    exp_ones = ((64'd1 << ew) - 64'd1) << fw;
    bias = (1 << (ew - 1)) - 1;
    emax = (1 << ew) - 2;
    r.ovf = 1'b0;
    if (dexp == 11'h7FF) begin
      r.bits = sign_pos | exp_ones;
      if (dfrac != 0) r.bits |= 64'd1 << (fw - 1);
    end else if (dexp == 0 && dfrac == 0) begin
      r.bits = sign_pos;
    end else begin
      if (dexp == 0) begin
        m = 64'(dfrac);
        e = -1022;
        while (!m[52]) begin
          m = m << 1;
          e--;
        end
      end else begin
        m = {11'd1, dfrac};
        e = int'(dexp) - 1023;
      end
      te = e + bias;
      if (te >= 1) begin
        q = (fw == 52) ? m : shift_rne(m, 52 - fw);
        // rounding carried into a new leading bit
        if ((q >> (fw + 1)) != 0) begin
          q = q >> 1;
          te++;
        end
        if (te > emax) begin
          r.bits = sign_pos | exp_ones;
          r.ovf = 1'b1;
        end else begin
          r.bits = sign_pos | (64'(te) << fw) | (q & ((64'd1 << fw) - 64'd1));
        end
      end else begin
        s = 53 - int'(fw) - te;
        q = (s >= 54) ? 64'd0 : shift_rne(m, s);
        r.bits = sign_pos | q;
      end
    end
    return r;
  endfunction

  // Random double biased toward the interesting range of the current format
  function automatic logic [63:0] pick_double();
    logic [63:0] v;
    int unsigned ew;
    int unsigned fw;
    int          bias;
    int          d;
    ew = eff_exp_w();
    fw = eff_frac_w();
    bias = (1 << (ew - 1)) - 1;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: ;
      1: begin
        v[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
        if ($urandom_range(0, 1)) v[51:0] = '0;
      end
      2: v[62:52] = '0;
      default: begin
        d = 1023 + int'($urandom_range(0, 2 * bias + fw + 10)) - (bias + int'(fw) + 5);
        if (d < 1) d = 1;
        if (d > 2046) d = 2046;
        v[62:52] = 11'(d);
        // force a rounding tie or all-ones tail now and then
        if (fw < 52 && $urandom_range(0, 2) == 0) begin
          v[51:0] = v[51:0] & ~((52'd1 << (52 - fw)) - 52'd1);
          if ($urandom_range(0, 1)) v[51:0] |= 52'd1 << (51 - fw);
          else v[51:0] |= (52'd1 << (52 - fw)) - 52'd1;
        end
      end
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    n_fail++;
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgDatWidth-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegExpWidth) exp_w_q = data[3:0];
    else frac_w_q = data;
  endtask

  // Send one transaction; the expectation is queued at acceptance
  task automatic send_double(input logic [63:0] v, input logic typed, input mini_t want);
    int unsigned gap;
    mini_t       pred;
    gap = send_burst ? 0 : $urandom_range(0, 9);
    pred = convert_double(v);
    if (typed && (pred.bits !== want.bits || pred.ovf !== want.ovf))
      report_mismatch($sformatf("table row %h: typed %h/%0b, predicted %h/%0b",
                                v, want.bits, want.ovf, pred.bits, pred.ovf));
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push_i <= 1'b1;
    value_bits_i <= v;
    do @(posedge clk_i); while (full_o);
    pending_q.push_back(typed ? want : pred);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    push_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Receiver: random pop pauses, check at each accepted transaction
  initial begin
    int unsigned wait_n;
    mini_t       want;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
      wait_n = recv_burst ? 0 : $urandom_range(0, 9);
      if (wait_n > 0) begin
        pop_i <= 1'b0;
        repeat (wait_n) @(negedge clk_i);
      end
      pop_i <= 1'b1;
      do @(posedge clk_i); while (empty_o);
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", result_bits_o));
      end else begin
        want = pending_q.pop_front();
        n_checked++;
        if (want.ovf) n_ovf++;
        if (result_bits_o !== want.bits)
          report_mismatch($sformatf("result_bits %h, expected %h", result_bits_o, want.bits));
        if (overflowed_o !== want.ovf)
          report_mismatch($sformatf("overflowed %b, expected %b", overflowed_o, want.ovf));
      end
    end
  end

  // Watchdog: stop when no transaction moves for too long
  initial begin
    forever begin
      @(posedge clk_i);
      if ((push_i && !full_o) || (pop_i && !empty_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transaction for %0d cycles", IdleLimit);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    vec_t        table_q[$];
    mini_t       want;
    int unsigned fmt_ew[$];
    int unsigned fmt_fw[$];
    // directed rows, typed values for the reset format (8/23)
    table_q = '{
      '{64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000, 1'b0},
      '{64'h8000_0000_0000_0000, 1'b1, 64'h8000_0000, 1'b0},
      '{64'h7FF0_0000_0000_0000, 1'b1, 64'h7F80_0000, 1'b0},
      '{64'hFFF0_0000_0000_0000, 1'b1, 64'hFF80_0000, 1'b0},
      '{64'h7FF8_0000_0000_0000, 1'b1, 64'h7FC0_0000, 1'b0},
      '{64'hFFF0_0000_0000_0001, 1'b1, 64'hFFC0_0000, 1'b0},
      '{64'h3FF0_0000_0000_0000, 1'b1, 64'h3F80_0000, 1'b0},
      '{64'hBFF0_0000_0000_0000, 1'b1, 64'hBF80_0000, 1'b0},
      '{64'h7FEF_FFFF_FFFF_FFFF, 1'b1, 64'h7F80_0000, 1'b1},
      '{64'hFFEF_FFFF_FFFF_FFFF, 1'b1, 64'hFF80_0000, 1'b1},
      '{64'h0000_0000_0000_0001, 1'b1, 64'h0000_0000, 1'b0},
      '{64'h000F_FFFF_FFFF_FFFF, 1'b1, 64'h0000_0000, 1'b0},
      '{64'h0010_0000_0000_0000, 1'b1, 64'h0000_0000, 1'b0},
      '{64'h3FF0_0000_1000_0000, 1'b0, 64'h0, 1'b0},
      '{64'h3FF0_0000_3000_0000, 1'b0, 64'h0, 1'b0},
      '{64'h3FFF_FFFF_F000_0000, 1'b0, 64'h0, 1'b0},
      '{64'h47EF_FFFF_EFFF_FFFF, 1'b0, 64'h0, 1'b0},
      '{64'h47EF_FFFF_F000_0000, 1'b0, 64'h0, 1'b0},
      '{64'h3810_0000_0000_0000, 1'b0, 64'h0, 1'b0},
      '{64'h380F_FFFF_F000_0000, 1'b0, 64'h0, 1'b0},
      '{64'h36A0_0000_0000_0000, 1'b0, 64'h0, 1'b0},
      '{64'h36A0_0000_0000_0001, 1'b0, 64'h0, 1'b0},
      '{64'h3690_0000_0000_0000, 1'b0, 64'h0, 1'b0},
      '{64'h5555_5555_AAAA_AAAA, 1'b0, 64'h0, 1'b0}
    };
    // formats after the reset one, out-of-range codes included
    fmt_ew = '{11, 2, 0, 15, 5, 4, 1, 12, 9};
    fmt_fw = '{52, 1, 0, 63, 10, 3, 2, 40, 52};

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (table_q[i]) begin
      want.bits = table_q[i].bits;
      want.ovf = table_q[i].ovf;
      send_double(table_q[i].value, table_q[i].typed, want);
    end
    for (int f = 0; f <= fmt_ew.size(); f++) begin
      if (f > 0) begin
        drain();
        write_reg(RegExpWidth, CfgDatWidth'(fmt_ew[f-1]));
        write_reg(RegFracWidth, CfgDatWidth'(fmt_fw[f-1]));
      end
      n_formats++;
      for (int k = 0; k < 3; k++) send_double(table_q[k*3].value, 1'b0, want);
      for (int k = 0; k < RandPerFmt - 25 * (f == 0 ? 1 : 0); k++) begin
        if (k % 40 == 0) send_burst = $urandom_range(0, 1);
        send_double(pick_double(), 1'b0, want);
      end
    end

    // wind down
    push_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    $display("%0d doubles sent and %0d results checked across %0d formats (%0d overflows)",
             n_sent, n_checked, n_formats, n_ovf);
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
